[hw/rtl/assert_macros.svh]
// Assertion macros used by the frame receiver RTL (frc_parse_core).
// No dependencies; the macros are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/frc_pkg.sv]
// Package for the frame receiver: status codes, register indexes, result type
// and the CRC-8 and ones'-complement helper functions. No dependencies.
`timescale 1ns / 1ps

package frc_pkg;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_GOOD     = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] CRC_POLY        = 8'h07;

  localparam int unsigned IDX_W = 17;

  typedef struct packed {
    logic             in_frame;
    logic [IDX_W-1:0] frame_index;
    status_t          status;
  } frc_result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, v};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[hw/rtl/frame_receiver_crc8_checksum.sv]
// Top level of the frame receiver: configuration registers, input register,
// parser core and result register. Depends on frc_pkg, frc_in_stage and frc_parse_core.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | in_rx_byte
//  out_    | output    | out_valid/out_stall| out_byte_out, out_in_frame, out_frame_index, out_status
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word is accepted per cycle while in_stall is low; it passes through the input register,
// and its result is then registered in the result register, from which it can be taken.
// The parser state update is a single pass of CRC-8, 16-bit add and compare logic.
// Reset loads sync bytes 0xAA and 0x55 and clears all frame state; cfg_ready is always high.
// A stall on the output holds the result register and, with the input register
// full, raises in_stall in the same cycle.

module frame_receiver_crc8_checksum
  import frc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte_out,
  output logic                 out_in_frame,
  output logic [IDX_W-1:0]     out_frame_index,
  output logic [1:0]           out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0]  sync_first_r;
  logic [7:0]  sync_second_r;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_can;
  logic        step;
  frc_result_t result;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  frc_result_t out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_can = !out_valid_r || !out_stall;
  assign step    = s1_valid && out_can;

  frc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (out_can),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  frc_parse_core u_parse_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (s1_byte),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .result      (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= s1_byte;
      out_res_r  <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = out_byte_r;
  assign out_in_frame    = out_res_r.in_frame;
  assign out_frame_index = out_res_r.frame_index;
  assign out_status      = out_res_r.status;

endmodule

[hw/rtl/frc_in_stage.sv]
// Input register of the frame receiver: holds one received word until the
// parser takes it. Depends on nothing but the handshake signals around it.
`timescale 1ns / 1ps

module frc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       load;

  assign in_stall = s1_valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

[hw/rtl/frc_parse_core.sv]
// Frame parser state and per-word logic: sync hunt, header CRC-8, length,
// body sum and trailer check. Depends on frc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frc_parse_core
  import frc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  sync_first,
  input  logic [7:0]  sync_second,
  output frc_result_t result
);

  localparam logic [IDX_W-1:0] IDX_SYNC1  = 17'd0;
  localparam logic [IDX_W-1:0] IDX_SYNC2  = 17'd1;
  localparam logic [IDX_W-1:0] IDX_LEN_LO = 17'd2;
  localparam logic [IDX_W-1:0] IDX_LEN_HI = 17'd3;
  localparam logic [IDX_W-1:0] IDX_CRC    = 17'd6;
  localparam logic [IDX_W-1:0] IDX_BODY   = 17'd7;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [7:0]       tlo_r, tlo_nxt;

  logic             kept;
  status_t          status;
  logic [IDX_W-1:0] lim;
  logic [15:0]      fin_sum;
  logic [15:0]      check;
  logic [15:0]      got;

  always_comb begin
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    crc_nxt  = crc_r;
    sum_nxt  = sum_r;
    held_nxt = held_r;
    tlo_nxt  = tlo_r;
    kept     = 1'b0;
    status   = ST_PROGRESS;
    lim      = {1'b0, len_r} + 17'd5;
    got      = {rx_byte, tlo_r};
    fin_sum  = len_r[0] ? ones_add(sum_r, {8'h00, held_r}) : sum_r;
    check    = (len_r == 16'd2) ? 16'h0000 : ~fin_sum;

    if (cnt_r == IDX_SYNC1) begin
      if (rx_byte == sync_first) begin
        kept     = 1'b1;
        crc_nxt  = crc8_step(8'h00, rx_byte);
        len_nxt  = 16'h0000;
        sum_nxt  = 16'h0000;
        held_nxt = 8'h00;
        tlo_nxt  = 8'h00;
        cnt_nxt  = IDX_SYNC2;
      end
    end else if (cnt_r == IDX_SYNC2) begin
      if (rx_byte == sync_second) begin
        kept    = 1'b1;
        crc_nxt = crc8_step(crc_r, rx_byte);
        cnt_nxt = IDX_LEN_LO;
      end else begin
        cnt_nxt = IDX_SYNC1;
      end
    end else if (cnt_r < IDX_CRC) begin
      kept    = 1'b1;
      crc_nxt = crc8_step(crc_r, rx_byte);
      if (cnt_r == IDX_LEN_LO) begin
        len_nxt = {len_r[15:8], rx_byte};
      end else if (cnt_r == IDX_LEN_HI) begin
        len_nxt = {rx_byte, len_r[7:0]};
      end
      cnt_nxt = cnt_r + 17'd1;
    end else if (cnt_r == IDX_CRC) begin
      kept = 1'b1;
      if (rx_byte != crc_r) begin
        cnt_nxt = IDX_SYNC1;
      end else if (len_r < 16'd2) begin
        status  = ST_BAD;
        cnt_nxt = IDX_SYNC1;
      end else begin
        cnt_nxt = IDX_BODY;
      end
    end else begin
      kept = 1'b1;
      if (cnt_r < lim) begin
        // Body words start at an odd frame position.
        if (cnt_r[0]) begin
          held_nxt = rx_byte;
        end else begin
          sum_nxt = ones_add(sum_r, {held_r, rx_byte});
        end
        cnt_nxt = cnt_r + 17'd1;
      end else if (cnt_r == lim) begin
        tlo_nxt = rx_byte;
        cnt_nxt = cnt_r + 17'd1;
      end else begin
        status  = (check == got) ? ST_GOOD : ST_BAD;
        cnt_nxt = IDX_SYNC1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      len_r  <= '0;
      crc_r  <= '0;
      sum_r  <= '0;
      held_r <= '0;
      tlo_r  <= '0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
      crc_r  <= crc_nxt;
      sum_r  <= sum_nxt;
      held_r <= held_nxt;
      tlo_r  <= tlo_nxt;
    end
  end

  assign result.in_frame    = kept;
  assign result.frame_index = kept ? cnt_r : '0;
  assign result.status      = status;

  `ASSERT_CLK(a_status_kept, clk, rst_n, (status != ST_PROGRESS) |-> kept, "status without kept word")
  `ASSERT_NEXT(a_end_resets, clk, rst_n, step && (status != ST_PROGRESS), cnt_r == IDX_SYNC1, "frame end did not restart the hunt")
  `ASSERT_CLK(a_cnt_bound, clk, rst_n, (cnt_r > IDX_BODY) |-> (cnt_r <= ({1'b0, len_r} + 17'd6)), "position past frame end")

endmodule

[test/testbench.sv]
// Self-checking testbench for frame_receiver_crc8_checksum: queues byte streams of sync,
// header, CRC-8, body and checksum words, predicts every result and checks it in order.
// Depends on frc_pkg and the frame receiver RTL.
`timescale 1ns / 1ps

module testbench;
  import frc_pkg::*;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_CRC,
    FR_BAD_SYNC
  } frame_kind_t;

  typedef struct {
    logic [7:0]       byte_val;
    logic             kept;
    logic [IDX_W-1:0] index;
    status_t          st;
  } rx_report_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd200;
  localparam int STUCK_LIMIT = 1000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte_out;
  logic                 out_in_frame;
  logic [IDX_W-1:0]     out_frame_index;
  logic [1:0]           out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;

  logic [7:0]  byte_stream[$];
  rx_report_t  pending_reports[$];
  int          queued_total = 0;
  int          err_count = 0;
  bit          quiet = 1'b0;

  logic [7:0]       sync_first_q = SYNC_FIRST_RST;
  logic [7:0]       sync_second_q = SYNC_SECOND_RST;
  logic [IDX_W-1:0] byte_count = '0;
  logic [15:0]      body_len = '0;
  logic [7:0]       hdr_crc = '0;
  logic [15:0]      body_sum = '0;
  logic [7:0]       held = '0;
  logic [7:0]       trailer_lo = '0;

  frame_receiver_crc8_checksum u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_out    (out_byte_out),
    .out_in_frame    (out_in_frame),
    .out_frame_index (out_frame_index),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      if (c[7] ^ b[k]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, v};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic rx_report_t parse_byte(input logic [7:0] b);
    rx_report_t       r;
    logic [IDX_W-1:0] idx;
    logic [17:0]      total;
    logic [15:0]      sum;
    logic [15:0]      check;
    idx = byte_count;
    r.byte_val = b;
    r.kept = 1'b0;
    r.st = ST_PROGRESS;
    if (idx == 0) begin
      if (b == sync_first_q) begin
        r.kept = 1'b1;
        hdr_crc = crc8_update(8'h00, b);
        body_len = '0;
        body_sum = '0;
        held = '0;
        trailer_lo = '0;
        byte_count = 1;
      end
    end else if (idx == 1) begin
      if (b == sync_second_q) begin
        r.kept = 1'b1;
        hdr_crc = crc8_update(hdr_crc, b);
        byte_count = 2;
      end else begin
        byte_count = 0;
      end
    end else if (idx < 6) begin
      r.kept = 1'b1;
      hdr_crc = crc8_update(hdr_crc, b);
      if (idx == 2) begin
        body_len[7:0] = b;
      end else if (idx == 3) begin
        body_len[15:8] = b;
      end
      byte_count = idx + 17'd1;
    end else if (idx == 6) begin
      r.kept = 1'b1;
      if (b != hdr_crc) begin
        byte_count = 0;
      end else if (body_len < 2) begin
        r.st = ST_BAD;
        byte_count = 0;
      end else begin
        byte_count = 7;
      end
    end else begin
      total = {2'b00, body_len} + 18'd7;
      r.kept = 1'b1;
      if ({1'b0, idx} < total - 18'd2) begin
        if (idx[0]) begin
          held = b;
        end else begin
          body_sum = fold_add(body_sum, {held, b});
        end
        byte_count = idx + 17'd1;
      end else if ({1'b0, idx} == total - 18'd2) begin
        trailer_lo = b;
        byte_count = idx + 17'd1;
      end else begin
        sum = body_sum;
        if (body_len[0]) begin
          sum = fold_add(sum, {8'h00, held});
        end
        check = (body_len == 16'd2) ? 16'h0000 : ~sum;
        r.st = (check == {b, trailer_lo}) ? ST_GOOD : ST_BAD;
        byte_count = 0;
      end
    end
    r.index = r.kept ? idx : '0;
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_stream.push_back(b);
    queued_total++;
  endtask

  task automatic queue_frame(input int len, input frame_kind_t kind);
    logic [7:0]  hdr[6];
    logic [7:0]  crc;
    logic [7:0]  bv;
    logic [7:0]  first;
    logic [15:0] sum;
    logic [15:0] chk;
    bit          all_ones;
    hdr[0] = sync_first_q;
    hdr[1] = sync_second_q;
    if (kind == FR_BAD_SYNC) begin
      push_byte(hdr[0]);
      push_byte(hdr[1] ^ 8'($urandom_range(1, 255)));
      return;
    end
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    hdr[4] = 8'($urandom);
    hdr[5] = 8'($urandom);
    crc = 8'h00;
    for (int i = 0; i < 6; i++) begin
      push_byte(hdr[i]);
      crc = crc8_update(crc, hdr[i]);
    end
    if (kind == FR_BAD_CRC) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    push_byte(crc);
    if (kind == FR_BAD_CRC || len < 2) begin
      return;
    end
    all_ones = ($urandom_range(0, 7) == 0);
    sum = 16'h0000;
    first = 8'h00;
    for (int i = 0; i < len - 2; i++) begin
      bv = all_ones ? 8'hFF : 8'($urandom);
      push_byte(bv);
      if (i % 2 == 0) begin
        first = bv;
      end else begin
        sum = fold_add(sum, {first, bv});
      end
    end
    if ((len - 2) % 2 == 1) begin
      sum = fold_add(sum, {8'h00, first});
    end
    chk = (len == 2) ? 16'h0000 : ~sum;
    if (kind == FR_BAD_SUM) begin
      chk = chk ^ 16'($urandom_range(1, 65535));
    end
    push_byte(chk[7:0]);
    push_byte(chk[15:8]);
  endtask

  function automatic int body_size();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(2, 24);
  endfunction

  task automatic fill_random(input int target);
    int start;
    int pick;
    start = queued_total;
    while (queued_total - start < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        queue_frame(body_size(), FR_GOOD);
      end else if (pick < 13) begin
        queue_frame(body_size(), FR_BAD_SUM);
      end else if (pick < 15) begin
        queue_frame($urandom_range(0, 65535), FR_BAD_CRC);
      end else if (pick == 15) begin
        queue_frame($urandom_range(0, 1), FR_GOOD);
      end else if (pick < 18) begin
        queue_frame(0, FR_BAD_SYNC);
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    while (byte_stream.size() != 0 || in_valid || pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SYNC_FIRST) begin
      sync_first_q = val;
    end else if (idx == CFG_SYNC_SECOND) begin
      sync_second_q = val;
    end
    cfg_valid <= 1'b0;
  endtask

  int in_gap = 0;
  int in_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_reports.push_back(parse_byte(in_rx_byte));
      end
      if (!in_valid || !in_stall) begin
        if (in_calm > 0) begin
          in_calm--;
        end else if (!quiet && $urandom_range(0, 39) == 0) begin
          in_calm = $urandom_range(20, 60);
        end
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && in_calm == 0 && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= byte_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int out_hold = 0;
  int out_calm = 0;

  always @(posedge clk) begin
    rx_report_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result: byte_out %0h", out_byte_out);
          err_count++;
        end else begin
          exp_r = pending_reports.pop_front();
          if (out_byte_out !== exp_r.byte_val) begin
            $error("byte_out: expected %0h, got %0h", exp_r.byte_val, out_byte_out);
            err_count++;
          end
          if (out_in_frame !== exp_r.kept) begin
            $error("in_frame: expected %0d, got %0d", exp_r.kept, out_in_frame);
            err_count++;
          end
          if (out_frame_index !== exp_r.index) begin
            $error("frame_index: expected %0d, got %0d", exp_r.index, out_frame_index);
            err_count++;
          end
          if (out_status !== exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, out_status);
            err_count++;
          end
        end
      end
      if (out_calm > 0) begin
        out_calm--;
      end else if (!quiet && $urandom_range(0, 39) == 0) begin
        out_calm = $urandom_range(20, 60);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (!quiet && out_calm == 0 && $urandom_range(0, 7) == 0) begin
        out_hold = $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  int stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_byte(8'h00);
    push_byte(8'hFF);
    queue_frame(0, FR_BAD_SYNC);
    queue_frame(1, FR_GOOD);
    queue_frame(2, FR_GOOD);
    queue_frame(16'h0203, FR_BAD_CRC);
    fill_random(100);
    wait_idle();

    write_reg(CFG_SYNC_FIRST, 8'h00);
    write_reg(CFG_SYNC_SECOND, 8'hFF);
    fill_random(100);
    wait_idle();

    write_reg(CFG_SYNC_FIRST, 8'hFF);
    write_reg(CFG_SYNC_SECOND, 8'h00);
    write_reg(CFG_IDX_SPARE, 8'($urandom));
    fill_random(60);
    fill_random(40);
    wait_idle();

    write_reg(CFG_SYNC_FIRST, 8'($urandom));
    write_reg(CFG_SYNC_SECOND, 8'($urandom));
    fill_random(100);
    wait_idle();

    write_reg(CFG_SYNC_FIRST, 8'h5A);
    write_reg(CFG_SYNC_SECOND, 8'h5A);
    fill_random(100);
    wait_idle();

    quiet = 1'b1;
    write_reg(CFG_SYNC_FIRST, SYNC_FIRST_RST);
    write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RST);
    fill_random(100);
    wait_idle();

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
